// ----- rtl/phf_pkg.sv -----
// Shared constants, command/status types and state encodings of the palindrome hash query unit.
package phf_pkg;

   // string store geometry
   localparam int MaxLen = 1024;
   localparam int AddrW  = $clog2(MaxLen);
   localparam int PosW   = 11;
   localparam int IdxW   = PosW + 1;
   localparam int CharW  = 8;

   // hash arithmetic
   localparam int HashW = 30;
   localparam int CntW  = $clog2(HashW);
   localparam logic [HashW-1:0] HashMod  = 30'd1000000007;
   localparam logic [HashW-1:0] HashBase = 30'd101;

   // reset length and set opcode
   localparam logic [PosW-1:0] LenReset = PosW'(MaxLen);
   localparam logic            OpcSet   = 1'b0;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_FILL_INIT,
      OP_FILL_WR,
      OP_CLR_WR,
      OP_DIFF,
      OP_MUL,
      OP_SAVE_F,
      OP_SAVE_B,
      OP_SAVE_P,
      OP_WALK,
      OP_CHAR_WR,
      OP_ACC_CLR,
      OP_PUT_MATCH,
      OP_PUT_ZERO
   } phf_op_type;

   // sources for the walk / memory index
   typedef enum logic [2:0] {
      IDX_ONE,
      IDX_L,
      IDX_L_M1,
      IDX_R,
      IDX_R_P1,
      IDX_NL,
      IDX_NR
   } phf_idx_type;

   // multiplier operand selection
   typedef enum logic [1:0] {
      MUL_FILL,
      MUL_SET,
      MUL_FWD,
      MUL_BWD
   } phf_mul_type;

   // what a tree walk step does
   typedef enum logic [1:0] {
      WM_UPD,
      WM_ADD,
      WM_SUB
   } phf_wmode_type;

   // the six tree walks
   typedef enum logic [2:0] {
      WALK_SET_F,
      WALK_SET_B,
      WALK_Q_F_R,
      WALK_Q_F_L,
      WALK_Q_B_L,
      WALK_Q_B_R
   } phf_walk_type;

   // controller states
   typedef enum logic [4:0] {
      ST_FILL_INIT,
      ST_FILL_MUL,
      ST_FILL_WAIT,
      ST_CLR_INIT,
      ST_CLR_WR,
      ST_IDLE,
      ST_DECODE,
      ST_SET_RD,
      ST_SET_DIFF,
      ST_SET_MULF,
      ST_SET_WAITF,
      ST_SET_RDB,
      ST_SET_MULB,
      ST_SET_WAITB,
      ST_SET_CHWR,
      ST_WCHK,
      ST_WSTEP,
      ST_Q_RD1,
      ST_Q_MUL1,
      ST_Q_WAIT1,
      ST_Q_RD2,
      ST_Q_MUL2,
      ST_Q_WAIT2,
      ST_Q_PUT
   } phf_state_type;

   // controller to datapath
   typedef struct packed {
      phf_op_type    op;
      logic          load_idx;
      phf_idx_type   idx_src;
      phf_mul_type   mul_sel;
      logic          tree_bwd;
      logic          walk_up;
      phf_wmode_type walk_mode;
   } phf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic idx_ok;
      logic sweep_last;
      logic mul_done;
      logic is_set;
      logic set_ok;
      logic qry_ok;
      logic rsp_free;
   } phf_status_type;

endpackage

// ----- rtl/palindrome_hash_fenwick_query_unit.sv -----
// Set and query time is dominated by the bit-serial modular multiplier (two uses per valid
// transaction) and the tree walk steps.
// One transaction at a time; a finished result waits in its output register meanwhile.
// Reset: synchronous; the power table is filled and the stores cleared before accepting.
// A length write in the idle state clears the string and both trees; otherwise only the length changes.
// Top level of the palindrome hash query unit: controller plus datapath.
module palindrome_hash_fenwick_query_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_opcode,
   input  logic [phf_pkg::PosW-1:0]   req_first_pos,
   input  logic [phf_pkg::PosW-1:0]   req_last_pos,
   input  logic [phf_pkg::CharW-1:0]  req_char_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_is_palindrome,
   input  logic                       csr_wr_en,
   input  logic [phf_pkg::PosW-1:0]   csr_wr_data
);

   phf_pkg::phf_cmd_type    cmd;
   phf_pkg::phf_status_type status;

   phf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_wr_en (csr_wr_en),
      .status    (status),
      .cmd       (cmd)
   );

   phf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_first_pos     (req_first_pos),
      .req_last_pos      (req_last_pos),
      .req_char_value    (req_char_value),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_is_palindrome (rsp_is_palindrome)
   );

endmodule

// ----- rtl/phf_mulmod.sv -----
// Bit-serial modular multiplier: one bit of the multiplier per cycle, result mod 1e9+7.
module phf_mulmod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [phf_pkg::HashW-1:0] a,
   input  logic [phf_pkg::HashW-1:0] b,
   output logic                      done,
   output logic [phf_pkg::HashW-1:0] result
);

   localparam logic [phf_pkg::HashW+1:0] OneMod = {2'b00, phf_pkg::HashMod};
   localparam logic [phf_pkg::HashW+1:0] TwoMod = {1'b0, phf_pkg::HashMod, 1'b0};

   logic [phf_pkg::HashW-1:0] a_ff, a_in;
   logic [phf_pkg::HashW-1:0] b_ff, b_in;
   logic [phf_pkg::HashW-1:0] acc_ff, acc_in;
   logic [phf_pkg::CntW-1:0]  cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [phf_pkg::HashW+1:0] sum_w;
   logic [phf_pkg::HashW+1:0] red_w;

   // double, add, reduce below the modulus
   always_comb begin
      sum_w = {1'b0, acc_ff, 1'b0} + (b_ff[phf_pkg::HashW-1] ? {2'b00, a_ff} : '0);
      if (sum_w >= TwoMod) begin
         red_w = sum_w - TwoMod;
      end else if (sum_w >= OneMod) begin
         red_w = sum_w - OneMod;
      end else begin
         red_w = sum_w;
      end
   end

   // sequencing
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = red_w[phf_pkg::HashW-1:0];
         b_in   = {b_ff[phf_pkg::HashW-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == phf_pkg::CntW'(phf_pkg::HashW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

// ----- rtl/phf_datapath.sv -----
// Datapath: string and tree memories, power table, walk index, accumulators and result register.
module phf_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  phf_pkg::phf_cmd_type       cmd,
   output phf_pkg::phf_status_type    status,
   input  logic                       req_opcode,
   input  logic [phf_pkg::PosW-1:0]   req_first_pos,
   input  logic [phf_pkg::PosW-1:0]   req_last_pos,
   input  logic [phf_pkg::CharW-1:0]  req_char_value,
   input  logic                       csr_wr_en,
   input  logic [phf_pkg::PosW-1:0]   csr_wr_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_is_palindrome
);

   function automatic logic [phf_pkg::HashW-1:0] add_mod(input logic [phf_pkg::HashW-1:0] x,
                                                         input logic [phf_pkg::HashW-1:0] y);
      logic [phf_pkg::HashW:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, phf_pkg::HashMod}) begin
         s = s - {1'b0, phf_pkg::HashMod};
      end
      return s[phf_pkg::HashW-1:0];
   endfunction

   function automatic logic [phf_pkg::HashW-1:0] sub_mod(input logic [phf_pkg::HashW-1:0] x,
                                                         input logic [phf_pkg::HashW-1:0] y);
      logic [phf_pkg::HashW-1:0] d;
      if (x >= y) begin
         d = x - y;
      end else begin
         d = x + (phf_pkg::HashMod - y);
      end
      return d;
   endfunction

   // memories
   logic [phf_pkg::CharW-1:0] char_mem [phf_pkg::MaxLen];
   logic [phf_pkg::HashW-1:0] fwd_mem  [phf_pkg::MaxLen];
   logic [phf_pkg::HashW-1:0] bwd_mem  [phf_pkg::MaxLen];
   logic [phf_pkg::HashW-1:0] pow_mem  [phf_pkg::MaxLen];
   logic [phf_pkg::CharW-1:0] char_q;
   logic [phf_pkg::HashW-1:0] fwd_q, bwd_q, pow_q;

   // registers
   logic [phf_pkg::PosW-1:0]  n_ff, n_in;
   logic                      op_ff, op_in;
   logic [phf_pkg::PosW-1:0]  l_ff, l_in;
   logic [phf_pkg::PosW-1:0]  r_ff, r_in;
   logic [phf_pkg::CharW-1:0] ch_ff, ch_in;
   logic [phf_pkg::IdxW-1:0]  idx_ff, idx_in;
   logic [phf_pkg::HashW-1:0] prev_ff, prev_in;
   logic [phf_pkg::HashW-1:0] diff_ff, diff_in;
   logic [phf_pkg::HashW-1:0] fdel_ff, fdel_in;
   logic [phf_pkg::HashW-1:0] bdel_ff, bdel_in;
   logic [phf_pkg::HashW-1:0] facc_ff, facc_in;
   logic [phf_pkg::HashW-1:0] bacc_ff, bacc_in;
   logic [phf_pkg::HashW-1:0] prod_ff, prod_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_pal_ff, rsp_pal_in;

   // internal nets
   logic [phf_pkg::AddrW-1:0] addr;
   logic [phf_pkg::IdxW-1:0]  low_bit;
   logic [phf_pkg::IdxW-1:0]  idx_src_val;
   logic [phf_pkg::IdxW-1:0]  n_ext, l_ext, r_ext;
   logic [phf_pkg::HashW-1:0] mul_a, mul_b, mul_res;
   logic                      mul_done;
   logic [phf_pkg::HashW-1:0] tree_q, tree_delta, tree_upd;
   logic                      clr_wr, fill_wr, walk_upd;
   logic                      char_we, fwd_we, bwd_we;
   logic [phf_pkg::CharW-1:0] char_wd;
   logic [phf_pkg::HashW-1:0] fwd_wd, bwd_wd;
   logic                      put;

   assign addr    = idx_ff[phf_pkg::AddrW-1:0];
   assign low_bit = idx_ff & (~idx_ff + 1'b1);
   assign n_ext   = {1'b0, n_ff};
   assign l_ext   = {1'b0, l_ff};
   assign r_ext   = {1'b0, r_ff};

   // status towards the controller
   assign status.idx_ok     = (idx_ff != '0) && (idx_ff <= n_ext);
   assign status.sweep_last = (idx_ff == phf_pkg::IdxW'(phf_pkg::MaxLen));
   assign status.mul_done   = mul_done;
   assign status.is_set     = (op_ff == phf_pkg::OpcSet);
   assign status.set_ok     = (l_ff != '0) && (l_ff <= n_ff);
   assign status.qry_ok     = (l_ff != '0) && (r_ff <= n_ff) && (l_ff <= r_ff);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   // index sources
   always_comb begin
      case (cmd.idx_src)
         phf_pkg::IDX_ONE:  idx_src_val = phf_pkg::IdxW'(1);
         phf_pkg::IDX_L:    idx_src_val = l_ext;
         phf_pkg::IDX_L_M1: idx_src_val = l_ext - 1'b1;
         phf_pkg::IDX_R:    idx_src_val = r_ext;
         phf_pkg::IDX_R_P1: idx_src_val = r_ext + 1'b1;
         phf_pkg::IDX_NL:   idx_src_val = n_ext - l_ext + 1'b1;
         phf_pkg::IDX_NR:   idx_src_val = n_ext - r_ext + 1'b1;
         default:           idx_src_val = phf_pkg::IdxW'(1);
      endcase
   end

   // multiplier operands
   always_comb begin
      mul_b = pow_q;
      case (cmd.mul_sel)
         phf_pkg::MUL_FILL: begin
            mul_a = prev_ff;
            mul_b = phf_pkg::HashBase;
         end
         phf_pkg::MUL_SET: mul_a = diff_ff;
         phf_pkg::MUL_FWD: mul_a = facc_ff;
         phf_pkg::MUL_BWD: mul_a = bacc_ff;
         default:          mul_a = prev_ff;
      endcase
   end

   phf_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.op == phf_pkg::OP_MUL),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   // tree walk arithmetic
   assign tree_q     = cmd.tree_bwd ? bwd_q : fwd_q;
   assign tree_delta = cmd.tree_bwd ? bdel_ff : fdel_ff;
   assign tree_upd   = add_mod(tree_q, tree_delta);

   // memory write controls
   assign fill_wr  = (cmd.op == phf_pkg::OP_FILL_WR);
   assign clr_wr   = fill_wr || (cmd.op == phf_pkg::OP_CLR_WR);
   assign walk_upd = (cmd.op == phf_pkg::OP_WALK) && (cmd.walk_mode == phf_pkg::WM_UPD);
   assign char_we  = clr_wr || (cmd.op == phf_pkg::OP_CHAR_WR);
   assign char_wd  = clr_wr ? '0 : ch_ff;
   assign fwd_we   = clr_wr || (walk_upd && !cmd.tree_bwd);
   assign bwd_we   = clr_wr || (walk_upd && cmd.tree_bwd);
   assign fwd_wd   = clr_wr ? '0 : tree_upd;
   assign bwd_wd   = clr_wr ? '0 : tree_upd;

   always_ff @(posedge clock) begin
      if (char_we) begin
         char_mem[addr] <= char_wd;
      end
      char_q <= char_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (fwd_we) begin
         fwd_mem[addr] <= fwd_wd;
      end
      fwd_q <= fwd_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (bwd_we) begin
         bwd_mem[addr] <= bwd_wd;
      end
      bwd_q <= bwd_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (fill_wr) begin
         pow_mem[addr] <= mul_res;
      end
      pow_q <= pow_mem[addr];
   end

   // register next values
   always_comb begin
      n_in    = n_ff;
      op_in   = op_ff;
      l_in    = l_ff;
      r_in    = r_ff;
      ch_in   = ch_ff;
      idx_in  = idx_ff;
      prev_in = prev_ff;
      diff_in = diff_ff;
      fdel_in = fdel_ff;
      bdel_in = bdel_ff;
      facc_in = facc_ff;
      bacc_in = bacc_ff;
      prod_in = prod_ff;
      put     = 1'b0;
      rsp_pal_in = rsp_pal_ff;

      // length register, clamped to 1..MaxLen
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            n_in = phf_pkg::PosW'(1);
         end else if (csr_wr_data > phf_pkg::PosW'(phf_pkg::MaxLen)) begin
            n_in = phf_pkg::PosW'(phf_pkg::MaxLen);
         end else begin
            n_in = csr_wr_data;
         end
      end

      case (cmd.op)
         phf_pkg::OP_LATCH: begin
            op_in = req_opcode;
            l_in  = req_first_pos;
            r_in  = req_last_pos;
            ch_in = req_char_value;
         end
         phf_pkg::OP_FILL_INIT: begin
            idx_in  = phf_pkg::IdxW'(1);
            prev_in = phf_pkg::HashW'(1);
         end
         phf_pkg::OP_FILL_WR: begin
            prev_in = mul_res;
            idx_in  = idx_ff + 1'b1;
         end
         phf_pkg::OP_CLR_WR: idx_in = idx_ff + 1'b1;
         phf_pkg::OP_DIFF: begin
            diff_in = sub_mod(phf_pkg::HashW'(ch_ff), phf_pkg::HashW'(char_q));
         end
         phf_pkg::OP_SAVE_F: fdel_in = mul_res;
         phf_pkg::OP_SAVE_B: bdel_in = mul_res;
         phf_pkg::OP_SAVE_P: prod_in = mul_res;
         phf_pkg::OP_ACC_CLR: begin
            facc_in = '0;
            bacc_in = '0;
         end
         phf_pkg::OP_WALK: begin
            idx_in = cmd.walk_up ? idx_ff + low_bit : idx_ff - low_bit;
            if (cmd.walk_mode == phf_pkg::WM_ADD) begin
               if (cmd.tree_bwd) begin
                  bacc_in = add_mod(bacc_ff, tree_q);
               end else begin
                  facc_in = add_mod(facc_ff, tree_q);
               end
            end else if (cmd.walk_mode == phf_pkg::WM_SUB) begin
               if (cmd.tree_bwd) begin
                  bacc_in = sub_mod(bacc_ff, tree_q);
               end else begin
                  facc_in = sub_mod(facc_ff, tree_q);
               end
            end
         end
         phf_pkg::OP_PUT_MATCH: begin
            put        = 1'b1;
            rsp_pal_in = (mul_res == prod_ff);
         end
         phf_pkg::OP_PUT_ZERO: begin
            put        = 1'b1;
            rsp_pal_in = 1'b0;
         end
         default: begin
         end
      endcase

      if (cmd.load_idx) begin
         idx_in = idx_src_val;
      end

      // result register
      if (put) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= phf_pkg::LenReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      ch_ff      <= ch_in;
      idx_ff     <= idx_in;
      prev_ff    <= prev_in;
      diff_ff    <= diff_in;
      fdel_ff    <= fdel_in;
      bdel_ff    <= bdel_in;
      facc_ff    <= facc_in;
      bacc_ff    <= bacc_in;
      prod_ff    <= prod_in;
      rsp_pal_ff <= rsp_pal_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_palindrome = rsp_pal_ff;

endmodule

// ----- rtl/phf_ctrl.sv -----
// Controller: sequences power fill, store clearing, set updates and range queries.
module phf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    csr_wr_en,
   input  phf_pkg::phf_status_type status,
   output phf_pkg::phf_cmd_type    cmd
);

   phf_pkg::phf_state_type state_ff, state_in;
   phf_pkg::phf_walk_type  walk_ff, walk_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= phf_pkg::ST_FILL_INIT;
         walk_ff  <= phf_pkg::WALK_SET_F;
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
      end
   end

   assign req_stall = (state_ff != phf_pkg::ST_IDLE) || csr_wr_en;

   always_comb begin
      state_in      = state_ff;
      walk_in       = walk_ff;
      cmd.op        = phf_pkg::OP_NONE;
      cmd.load_idx  = 1'b0;
      cmd.idx_src   = phf_pkg::IDX_ONE;
      cmd.mul_sel   = phf_pkg::MUL_FILL;
      cmd.tree_bwd  = 1'b0;
      cmd.walk_up   = 1'b0;
      cmd.walk_mode = phf_pkg::WM_UPD;

      // walk attributes
      cmd.tree_bwd = (walk_ff inside {phf_pkg::WALK_SET_B, phf_pkg::WALK_Q_B_L,
                                      phf_pkg::WALK_Q_B_R});
      cmd.walk_up  = (walk_ff inside {phf_pkg::WALK_SET_F, phf_pkg::WALK_Q_B_L,
                                      phf_pkg::WALK_Q_B_R});
      case (walk_ff)
         phf_pkg::WALK_Q_F_R, phf_pkg::WALK_Q_B_L: cmd.walk_mode = phf_pkg::WM_ADD;
         phf_pkg::WALK_Q_F_L, phf_pkg::WALK_Q_B_R: cmd.walk_mode = phf_pkg::WM_SUB;
         default:                                  cmd.walk_mode = phf_pkg::WM_UPD;
      endcase

      case (state_ff)
         // power table fill with store clear after reset
         phf_pkg::ST_FILL_INIT: begin
            cmd.op   = phf_pkg::OP_FILL_INIT;
            state_in = phf_pkg::ST_FILL_MUL;
         end
         phf_pkg::ST_FILL_MUL: begin
            cmd.op      = phf_pkg::OP_MUL;
            cmd.mul_sel = phf_pkg::MUL_FILL;
            state_in    = phf_pkg::ST_FILL_WAIT;
         end
         phf_pkg::ST_FILL_WAIT: begin
            if (status.mul_done) begin
               cmd.op   = phf_pkg::OP_FILL_WR;
               state_in = status.sweep_last ? phf_pkg::ST_IDLE : phf_pkg::ST_FILL_MUL;
            end
         end

         // store clear after a length write
         phf_pkg::ST_CLR_INIT: begin
            cmd.load_idx = 1'b1;
            cmd.idx_src  = phf_pkg::IDX_ONE;
            state_in     = phf_pkg::ST_CLR_WR;
         end
         phf_pkg::ST_CLR_WR: begin
            cmd.op = phf_pkg::OP_CLR_WR;
            if (status.sweep_last) begin
               state_in = phf_pkg::ST_IDLE;
            end
         end

         phf_pkg::ST_IDLE: begin
            if (csr_wr_en) begin
               state_in = phf_pkg::ST_CLR_INIT;
            end else if (req_valid) begin
               cmd.op   = phf_pkg::OP_LATCH;
               state_in = phf_pkg::ST_DECODE;
            end
         end

         phf_pkg::ST_DECODE: begin
            if (status.is_set) begin
               if (status.set_ok) begin
                  cmd.load_idx = 1'b1;
                  cmd.idx_src  = phf_pkg::IDX_L;
                  state_in     = phf_pkg::ST_SET_RD;
               end else begin
                  state_in = phf_pkg::ST_IDLE;
               end
            end else if (status.qry_ok) begin
               cmd.op       = phf_pkg::OP_ACC_CLR;
               cmd.load_idx = 1'b1;
               cmd.idx_src  = phf_pkg::IDX_R;
               walk_in      = phf_pkg::WALK_Q_F_R;
               state_in     = phf_pkg::ST_WCHK;
            end else if (status.rsp_free) begin
               cmd.op   = phf_pkg::OP_PUT_ZERO;
               state_in = phf_pkg::ST_IDLE;
            end
         end

         // set: weighted deltas for both trees
         phf_pkg::ST_SET_RD:   state_in = phf_pkg::ST_SET_DIFF;
         phf_pkg::ST_SET_DIFF: begin
            cmd.op   = phf_pkg::OP_DIFF;
            state_in = phf_pkg::ST_SET_MULF;
         end
         phf_pkg::ST_SET_MULF: begin
            cmd.op      = phf_pkg::OP_MUL;
            cmd.mul_sel = phf_pkg::MUL_SET;
            state_in    = phf_pkg::ST_SET_WAITF;
         end
         phf_pkg::ST_SET_WAITF: begin
            if (status.mul_done) begin
               cmd.op       = phf_pkg::OP_SAVE_F;
               cmd.load_idx = 1'b1;
               cmd.idx_src  = phf_pkg::IDX_NL;
               state_in     = phf_pkg::ST_SET_RDB;
            end
         end
         phf_pkg::ST_SET_RDB:  state_in = phf_pkg::ST_SET_MULB;
         phf_pkg::ST_SET_MULB: begin
            cmd.op      = phf_pkg::OP_MUL;
            cmd.mul_sel = phf_pkg::MUL_SET;
            state_in    = phf_pkg::ST_SET_WAITB;
         end
         phf_pkg::ST_SET_WAITB: begin
            if (status.mul_done) begin
               cmd.op       = phf_pkg::OP_SAVE_B;
               cmd.load_idx = 1'b1;
               cmd.idx_src  = phf_pkg::IDX_L;
               walk_in      = phf_pkg::WALK_SET_F;
               state_in     = phf_pkg::ST_WCHK;
            end
         end
         phf_pkg::ST_SET_CHWR: begin
            cmd.op   = phf_pkg::OP_CHAR_WR;
            state_in = phf_pkg::ST_IDLE;
         end

         // tree walks: check index, then one update or accumulate step
         phf_pkg::ST_WCHK: begin
            if (status.idx_ok) begin
               state_in = phf_pkg::ST_WSTEP;
            end else begin
               cmd.load_idx = 1'b1;
               case (walk_ff)
                  phf_pkg::WALK_SET_F: begin
                     cmd.idx_src = phf_pkg::IDX_L;
                     walk_in     = phf_pkg::WALK_SET_B;
                  end
                  phf_pkg::WALK_SET_B: begin
                     cmd.idx_src = phf_pkg::IDX_L;
                     state_in    = phf_pkg::ST_SET_CHWR;
                  end
                  phf_pkg::WALK_Q_F_R: begin
                     cmd.idx_src = phf_pkg::IDX_L_M1;
                     walk_in     = phf_pkg::WALK_Q_F_L;
                  end
                  phf_pkg::WALK_Q_F_L: begin
                     cmd.idx_src = phf_pkg::IDX_L;
                     walk_in     = phf_pkg::WALK_Q_B_L;
                  end
                  phf_pkg::WALK_Q_B_L: begin
                     cmd.idx_src = phf_pkg::IDX_R_P1;
                     walk_in     = phf_pkg::WALK_Q_B_R;
                  end
                  default: begin
                     cmd.idx_src = phf_pkg::IDX_NR;
                     state_in    = phf_pkg::ST_Q_RD1;
                  end
               endcase
            end
         end
         phf_pkg::ST_WSTEP: begin
            cmd.op   = phf_pkg::OP_WALK;
            state_in = phf_pkg::ST_WCHK;
         end

         // query: cross-multiply sums by the opposite powers and compare
         phf_pkg::ST_Q_RD1:  state_in = phf_pkg::ST_Q_MUL1;
         phf_pkg::ST_Q_MUL1: begin
            cmd.op      = phf_pkg::OP_MUL;
            cmd.mul_sel = phf_pkg::MUL_FWD;
            state_in    = phf_pkg::ST_Q_WAIT1;
         end
         phf_pkg::ST_Q_WAIT1: begin
            if (status.mul_done) begin
               cmd.op       = phf_pkg::OP_SAVE_P;
               cmd.load_idx = 1'b1;
               cmd.idx_src  = phf_pkg::IDX_L;
               state_in     = phf_pkg::ST_Q_RD2;
            end
         end
         phf_pkg::ST_Q_RD2:  state_in = phf_pkg::ST_Q_MUL2;
         phf_pkg::ST_Q_MUL2: begin
            cmd.op      = phf_pkg::OP_MUL;
            cmd.mul_sel = phf_pkg::MUL_BWD;
            state_in    = phf_pkg::ST_Q_WAIT2;
         end
         phf_pkg::ST_Q_WAIT2: begin
            if (status.mul_done) begin
               state_in = phf_pkg::ST_Q_PUT;
            end
         end
         phf_pkg::ST_Q_PUT: begin
            if (status.rsp_free) begin
               cmd.op   = phf_pkg::OP_PUT_MATCH;
               state_in = phf_pkg::ST_IDLE;
            end
         end

         default: state_in = phf_pkg::ST_IDLE;
      endcase
   end

endmodule
